### src/lcdisp_pkg.sv
`timescale 1ns / 1ps

package lcdisp_pkg;

  // Sequencer phase within a script
  typedef enum logic [2:0] {
    PH_COUNT = 3'd0,
    PH_CMD   = 3'd1,
    PH_NARGS = 3'd2,
    PH_ARGS  = 3'd3,
    PH_DELAY = 3'd4
  } phase_e;

  // Kind of a result transfer on the display link
  typedef enum logic [1:0] {
    KIND_CMD   = 2'd0,
    KIND_ARG   = 2'd1,
    KIND_DELAY = 2'd2
  } kind_e;

  localparam logic [15:0] LONG_DELAY_RESET = 16'd500;
  localparam logic [7:0]  DELAY_LONG_CODE  = 8'hFF;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  byte_value;
    logic [15:0] wait_ms;
    logic        end_of_command;
    logic        script_done;
  } result_t;

endpackage

### src/lcdisp_seq.sv
`timescale 1ns / 1ps

module lcdisp_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_fire_i,
  input  logic [7:0]          script_byte_i,
  input  logic [15:0]         long_delay_i,
  output logic                res_valid_o,
  output lcdisp_pkg::result_t res_o
);

  lcdisp_pkg::phase_e phase_q, phase_d;
  logic [7:0] commands_left_q, commands_left_d;
  logic [6:0] args_left_q, args_left_d;
  logic       delay_pending_q, delay_pending_d;
  logic [7:0] held_command_q, held_command_d;

  logic [7:0] cmd_dec;
  logic       last_cmd;
  logic [6:0] args_dec;

  assign cmd_dec  = commands_left_q - 8'd1;
  assign last_cmd = (cmd_dec == 8'd0);
  assign args_dec = args_left_q - 7'd1;

  // Decode one script byte against the current phase
  always_comb begin
    phase_d         = phase_q;
    commands_left_d = commands_left_q;
    args_left_d     = args_left_q;
    delay_pending_d = delay_pending_q;
    held_command_d  = held_command_q;
    res_valid_o     = 1'b0;
    res_o           = '{kind: lcdisp_pkg::KIND_CMD, byte_value: 8'd0, wait_ms: 16'd0,
                        end_of_command: 1'b0, script_done: 1'b0};
    case (phase_q)
      lcdisp_pkg::PH_CMD: begin
        held_command_d = script_byte_i;
        phase_d        = lcdisp_pkg::PH_NARGS;
      end
      lcdisp_pkg::PH_NARGS: begin
        args_left_d       = script_byte_i[6:0];
        delay_pending_d   = script_byte_i[7];
        res_valid_o       = 1'b1;
        res_o.kind        = lcdisp_pkg::KIND_CMD;
        res_o.byte_value  = held_command_q;
        if (script_byte_i[6:0] != 7'd0) begin
          phase_d = lcdisp_pkg::PH_ARGS;
        end else if (script_byte_i[7]) begin
          phase_d              = lcdisp_pkg::PH_DELAY;
          res_o.end_of_command = 1'b1;
        end else begin
          commands_left_d      = cmd_dec;
          phase_d              = last_cmd ? lcdisp_pkg::PH_COUNT : lcdisp_pkg::PH_CMD;
          res_o.end_of_command = 1'b1;
          res_o.script_done    = last_cmd;
        end
      end
      lcdisp_pkg::PH_ARGS: begin
        args_left_d      = args_dec;
        res_valid_o      = 1'b1;
        res_o.kind       = lcdisp_pkg::KIND_ARG;
        res_o.byte_value = script_byte_i;
        if (args_dec != 7'd0) begin
          phase_d = lcdisp_pkg::PH_ARGS;
        end else if (delay_pending_q) begin
          phase_d              = lcdisp_pkg::PH_DELAY;
          res_o.end_of_command = 1'b1;
        end else begin
          commands_left_d      = cmd_dec;
          phase_d              = last_cmd ? lcdisp_pkg::PH_COUNT : lcdisp_pkg::PH_CMD;
          res_o.end_of_command = 1'b1;
          res_o.script_done    = last_cmd;
        end
      end
      lcdisp_pkg::PH_DELAY: begin
        delay_pending_d   = 1'b0;
        commands_left_d   = cmd_dec;
        phase_d           = last_cmd ? lcdisp_pkg::PH_COUNT : lcdisp_pkg::PH_CMD;
        res_valid_o       = 1'b1;
        res_o.kind        = lcdisp_pkg::KIND_DELAY;
        res_o.wait_ms     = (script_byte_i == lcdisp_pkg::DELAY_LONG_CODE) ?
                            long_delay_i : {8'd0, script_byte_i};
        res_o.script_done = last_cmd;
      end
      default: begin
        // Count byte: start a script, or keep waiting on an empty one
        commands_left_d = script_byte_i;
        args_left_d     = 7'd0;
        delay_pending_d = 1'b0;
        phase_d         = (script_byte_i != 8'd0) ? lcdisp_pkg::PH_CMD : lcdisp_pkg::PH_COUNT;
      end
    endcase
  end

  // Advance the sequencer on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= lcdisp_pkg::PH_COUNT;
      commands_left_q <= 8'd0;
      args_left_q     <= 7'd0;
      delay_pending_q <= 1'b0;
      held_command_q  <= 8'd0;
    end else if (in_fire_i) begin
      phase_q         <= phase_d;
      commands_left_q <= commands_left_d;
      args_left_q     <= args_left_d;
      delay_pending_q <= delay_pending_d;
      held_command_q  <= held_command_d;
    end
  end

  a_count_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i && phase_q == lcdisp_pkg::PH_COUNT && script_byte_i != 8'd0
    |=> phase_q == lcdisp_pkg::PH_CMD)
    else $error("nonzero count did not start a script");

  a_no_result_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> phase_q != lcdisp_pkg::PH_COUNT && phase_q != lcdisp_pkg::PH_CMD)
    else $error("result produced for a count or command byte");

  a_done_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i && res_valid_o && res_o.script_done |=> phase_q == lcdisp_pkg::PH_COUNT)
    else $error("script end did not return to awaiting a count");

endmodule

### src/lcdisp_out_reg.sv
`timescale 1ns / 1ps

module lcdisp_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                res_valid_i,
  input  lcdisp_pkg::result_t res_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lcdisp_pkg::result_t out_o
);

  logic                out_valid_q, out_valid_d;
  lcdisp_pkg::result_t out_q;
  logic                load;

  // Take a new byte whenever the held result is empty or leaving
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign load        = in_valid_i && in_ready_o && res_valid_i;
  assign out_valid_d = load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload until transfer
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_q && !out_ready_i)
    else $error("input stalled while output stage could move");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q)
    else $error("loaded result not presented");

  a_hold_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q))
    else $error("waiting result changed before transfer");

endmodule

### src/lcd_init_script_player.sv
`timescale 1ns / 1ps

// Display init script player. Takes one script byte per cycle on the input
// channel and turns it into command bytes (DC low), argument bytes (DC high)
// and delay requests for the display link, with chip-select release and
// end-of-script flags. Each byte is decoded combinationally and its result, if
// any, lands in a single output register; count and command bytes give no
// result of their own (a command byte leaves with its argument-count byte).
// A byte is taken every cycle unless the output register holds a result the
// consumer has not yet taken, so throughput is one byte per cycle under no
// backpressure, and the result is valid in the cycle after its input transfer.
// The long-delay register (reset 500 ms) is written through its own channel,
// always ready, and is used for delay bytes of 255.

module lcd_init_script_player (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] long_delay_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  script_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  byte_value_o,
  output logic [15:0] wait_ms_o,
  output logic        end_of_command_o,
  output logic        script_done_o
);

  logic [15:0]         long_delay_q;
  logic                in_fire;
  logic                res_valid;
  lcdisp_pkg::result_t res;
  lcdisp_pkg::result_t out;

  // Long-delay register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_delay_q <= lcdisp_pkg::LONG_DELAY_RESET;
    end else if (cfg_valid_i) begin
      long_delay_q <= long_delay_i;
    end
  end

  assign in_fire = in_valid_i && in_ready_o;

  lcdisp_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_fire_i     (in_fire),
    .script_byte_i (script_byte_i),
    .long_delay_i  (long_delay_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  lcdisp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out)
  );

  assign kind_o           = out.kind;
  assign byte_value_o     = out.byte_value;
  assign wait_ms_o        = out.wait_ms;
  assign end_of_command_o = out.end_of_command;
  assign script_done_o    = out.script_done;

endmodule
